// ===== hw/rtl/ppf_pkg.sv =====
package ppf_pkg;

  localparam int MaxBins    = 1024;
  localparam int Lanes      = 4;
  localparam int SampleBits = 16;
  localparam int BinBits    = 10;
  localparam int CountBits  = 11;
  localparam int SumBits    = 32;

  localparam logic [1:0] REQ_FOLD    = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_RESTART = 2'd3;

  localparam logic [1:0] CFG_PHASE_STEP    = 2'd0;
  localparam logic [1:0] CFG_INITIAL_PHASE = 2'd1;
  localparam logic [1:0] CFG_BIN_COUNT     = 2'd2;
  localparam logic [1:0] CFG_ZEROED_MODE   = 2'd3;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [BinBits-1:0]           bin_select;
    logic signed [SampleBits-1:0] sample_0;
    logic signed [SampleBits-1:0] sample_1;
    logic signed [SampleBits-1:0] sample_2;
    logic signed [SampleBits-1:0] sample_3;
    logic                         weight_zero;
  } in_item_t;

  typedef struct packed {
    logic [BinBits-1:0]        bin_index;
    logic                      discarded;
    logic signed [SumBits-1:0] sum_0;
    logic signed [SumBits-1:0] sum_1;
    logic signed [SumBits-1:0] sum_2;
    logic signed [SumBits-1:0] sum_3;
    logic [31:0]               hit_count;
  } out_item_t;

  // Control that travels from the sequencer to every lane.
  typedef struct packed {
    logic               rd;     // read the row at addr
    logic               wr;     // write back the row at addr
    logic               clr;    // write zero instead of the update
    logic               add;    // add the sample into the old value
    logic [BinBits-1:0] addr;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/pulse_phase_folder_top.sv =====
// Pulse phase folder: folds a stream of four-lane samples into phase bins.
// Input channel (in_valid/in_ready/in_item) carries requests: fold a sample,
// read a bin, read and clear a bin, or restart the phase accumulator.
// Output channel (out_valid/out_ready/out_item) returns one item per request.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
// Every request passes through three steps: accept, read of the bin row in
// all lane memories and the hit memory, then write back and result. The
// result is registered at the end of the write-back step, and the block takes
// no new item until the last one is through: the next item is accepted in the
// cycle in which the result is taken, because of the read-modify-write of the
// bin memories.
// Reset clears the phase, sets the settings to defaults and then sweeps all
// 1024 bins to zero, one bin a cycle; no item is accepted meanwhile.
// When the receiver stalls, the result holds in the output register and the
// block accepts no further item until the cycle in which it is taken.
module pulse_phase_folder_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ppf_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppf_pkg::out_item_t   out_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]  state;
  logic [31:0] phase_step;
  logic [31:0] initial_phase;
  logic [ppf_pkg::CountBits-1:0] bin_count;
  logic        zeroed_mode;
  logic [31:0] phase_accum;
  logic [ppf_pkg::CountBits-1:0] clr_cnt;

  ppf_pkg::in_item_t item;
  logic [ppf_pkg::BinBits-1:0] bin;
  logic        drop;
  logic        hit;

  logic [ppf_pkg::CountBits-1:0] eff;
  logic [42:0] prod;
  logic [ppf_pkg::CountBits-1:0] raw_bin;
  logic [ppf_pkg::BinBits-1:0]   fold_bin;
  ppf_pkg::out_item_t acc_item;

  ppf_pkg::lane_ctl_t sum_ctl;
  ppf_pkg::lane_ctl_t hit_ctl;
  logic signed [ppf_pkg::SumBits-1:0] rd [ppf_pkg::Lanes];
  logic [31:0] hits_rd;
  logic [ppf_pkg::SampleBits-1:0] smp [ppf_pkg::Lanes];

  // A new item may enter in the same cycle as the waiting result leaves.
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  always_comb begin
    if (bin_count == '0) begin
      eff = ppf_pkg::CountBits'(1);
    end else if (bin_count > ppf_pkg::CountBits'(ppf_pkg::MaxBins)) begin
      eff = ppf_pkg::CountBits'(ppf_pkg::MaxBins);
    end else begin
      eff = bin_count;
    end
    prod = {11'd0, phase_accum} * {32'd0, eff};
    raw_bin = prod[42:32];
    if (raw_bin >= eff) begin
      fold_bin = ppf_pkg::BinBits'(eff - ppf_pkg::CountBits'(1));
    end else begin
      fold_bin = raw_bin[ppf_pkg::BinBits-1:0];
    end
  end

  // The part of the result known at acceptance; sums and hits of reads and clears follow later.
  always_comb begin
    acc_item = '0;
    if (in_item.req_type == ppf_pkg::REQ_FOLD) begin
      acc_item.bin_index = fold_bin;
      acc_item.discarded = !zeroed_mode && in_item.weight_zero;
    end else if (in_item.req_type != ppf_pkg::REQ_RESTART) begin
      acc_item.bin_index = in_item.bin_select;
    end
  end

  assign smp[0] = item.sample_0;
  assign smp[1] = item.sample_1;
  assign smp[2] = item.sample_2;
  assign smp[3] = item.sample_3;

  // The same bin row is shared by all lanes; only fold adds, clear zeroes.
  always_comb begin
    sum_ctl = '0;
    hit_ctl = '0;
    unique case (state)
      ST_CLEAR: begin
        sum_ctl.wr   = 1'b1;
        sum_ctl.clr  = 1'b1;
        sum_ctl.addr = clr_cnt[ppf_pkg::BinBits-1:0];
        hit_ctl      = sum_ctl;
      end
      ST_READ: begin
        sum_ctl.rd   = 1'b1;
        sum_ctl.addr = bin;
        hit_ctl      = sum_ctl;
      end
      ST_WRITE: begin
        sum_ctl.addr = bin;
        sum_ctl.wr   = (item.req_type == ppf_pkg::REQ_CLEAR)
                    || (item.req_type == ppf_pkg::REQ_FOLD && !drop);
        sum_ctl.clr  = (item.req_type == ppf_pkg::REQ_CLEAR);
        sum_ctl.add  = (item.req_type == ppf_pkg::REQ_FOLD);
        hit_ctl      = sum_ctl;
        hit_ctl.add  = sum_ctl.add && hit;
      end
      default: begin
      end
    endcase
  end

  for (genvar l = 0; l < ppf_pkg::Lanes; l++) begin : g_lane
    ppf_lane u_lane (
      .clk     (clk),
      .ctl     (sum_ctl),
      .sample  (smp[l]),
      .rd_data (rd[l])
    );
  end

  ppf_hits u_hits (
    .clk     (clk),
    .ctl     (hit_ctl),
    .rd_data (hits_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      phase_step    <= '0;
      initial_phase <= '0;
      bin_count     <= ppf_pkg::CountBits'(ppf_pkg::MaxBins);
      zeroed_mode   <= 1'b0;
      phase_accum   <= '0;
      clr_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ppf_pkg::CFG_PHASE_STEP:    phase_step    <= cfg_data;
          ppf_pkg::CFG_INITIAL_PHASE: initial_phase <= cfg_data;
          ppf_pkg::CFG_BIN_COUNT:     bin_count     <= cfg_data[ppf_pkg::CountBits-1:0];
          ppf_pkg::CFG_ZEROED_MODE:   zeroed_mode   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ppf_pkg::CountBits'(ppf_pkg::MaxBins - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            item     <= in_item;
            drop     <= !zeroed_mode && in_item.weight_zero;
            hit      <= !zeroed_mode || (in_item.sample_0 != '0);
            out_item <= acc_item;
            if (in_item.req_type == ppf_pkg::REQ_FOLD) begin
              bin         <= fold_bin;
              phase_accum <= phase_accum + phase_step;
            end else begin
              bin <= in_item.bin_select;
              if (in_item.req_type == ppf_pkg::REQ_RESTART) begin
                phase_accum <= initial_phase;
              end
            end
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (item.req_type == ppf_pkg::REQ_READ || item.req_type == ppf_pkg::REQ_CLEAR) begin
            out_item.sum_0     <= rd[0];
            out_item.sum_1     <= rd[1];
            out_item.sum_2     <= rd[2];
            out_item.sum_3     <= rd[3];
            out_item.hit_count <= hits_rd;
          end
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ppf_lane.sv =====
module ppf_lane (
  input  logic                                   clk,
  input  ppf_pkg::lane_ctl_t                     ctl,
  input  logic signed [ppf_pkg::SampleBits-1:0]  sample,
  output logic signed [ppf_pkg::SumBits-1:0]     rd_data
);

  logic signed [ppf_pkg::SumBits-1:0] mem [ppf_pkg::MaxBins];
  logic signed [ppf_pkg::SumBits:0]   wide;
  logic signed [ppf_pkg::SumBits-1:0] upd;

  always_comb begin
    wide = {rd_data[ppf_pkg::SumBits-1], rd_data}
         + (ppf_pkg::SumBits+1)'(sample);
    if (wide[ppf_pkg::SumBits] != wide[ppf_pkg::SumBits-1]) begin
      upd = wide[ppf_pkg::SumBits] ? {1'b1, {(ppf_pkg::SumBits-1){1'b0}}}
                                   : {1'b0, {(ppf_pkg::SumBits-1){1'b1}}};
    end else begin
      upd = wide[ppf_pkg::SumBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data <= mem[ctl.addr];
    end
    if (ctl.wr) begin
      if (ctl.clr) begin
        mem[ctl.addr] <= '0;
      end else if (ctl.add) begin
        mem[ctl.addr] <= upd;
      end
    end
  end

endmodule

// ===== hw/rtl/ppf_hits.sv =====
module ppf_hits (
  input  logic               clk,
  input  ppf_pkg::lane_ctl_t ctl,
  output logic [31:0]        rd_data
);

  logic [31:0] mem [ppf_pkg::MaxBins];

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data <= mem[ctl.addr];
    end
    if (ctl.wr) begin
      if (ctl.clr) begin
        mem[ctl.addr] <= '0;
      end else if (ctl.add && rd_data != 32'hFFFF_FFFF) begin
        mem[ctl.addr] <= rd_data + 32'd1;
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import ppf_pkg::*;

  // Clock and reset. Reset is synchronous.
  logic clk;
  logic rst;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  pulse_phase_folder_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The predictor keeps its own copy of the settings and of both stores.
  logic [31:0]        step_reg;
  logic [31:0]        start_phase_reg;
  logic [10:0]        bins_reg;
  logic               zeroed_reg;
  logic [31:0]        phase;
  logic signed [31:0] lane_sums [MaxBins][Lanes];
  logic [31:0]        hits [MaxBins];

  out_item_t expected_results [$];
  int        failures;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  // Signed add that clamps to the 32-bit range.
  function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
                                                   logic signed [15:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'h7fff_ffff;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // Computes the result of one accepted request and updates the model state.
  function automatic out_item_t fold_predict(in_item_t it);
    out_item_t r;
    logic [11:0] eff;
    logic [63:0] prod;
    logic [9:0]  bin;
    logic        drop;
    logic signed [15:0] smp [Lanes];
    r = '0;
    smp[0] = it.sample_0; smp[1] = it.sample_1;
    smp[2] = it.sample_2; smp[3] = it.sample_3;
    case (it.req_type)
      REQ_FOLD: begin
        eff = {1'b0, bins_reg};
        if (eff == 0) eff = 1;
        if (eff > MaxBins) eff = MaxBins;
        prod = {32'd0, phase} * {52'd0, eff};
        if (prod[63:32] >= eff) bin = 10'(eff - 12'd1);
        else bin = prod[41:32];
        phase = phase + step_reg;
        drop = !zeroed_reg && it.weight_zero;
        if (!drop) begin
          for (int l = 0; l < Lanes; l++)
            lane_sums[bin][l] = clamp_add(lane_sums[bin][l], smp[l]);
          if ((!zeroed_reg || smp[0] != 0) && hits[bin] != 32'hffff_ffff)
            hits[bin] = hits[bin] + 1;
        end
        r.bin_index = bin;
        r.discarded = drop;
      end
      REQ_READ, REQ_CLEAR: begin
        r.bin_index = it.bin_select;
        r.sum_0 = lane_sums[it.bin_select][0];
        r.sum_1 = lane_sums[it.bin_select][1];
        r.sum_2 = lane_sums[it.bin_select][2];
        r.sum_3 = lane_sums[it.bin_select][3];
        r.hit_count = hits[it.bin_select];
        if (it.req_type == REQ_CLEAR) begin
          for (int l = 0; l < Lanes; l++) lane_sums[it.bin_select][l] = 0;
          hits[it.bin_select] = 0;
        end
      end
      default: phase = start_phase_reg;
    endcase
    return r;
  endfunction

  // Result checking: every accepted output item is compared field by field
  // with the oldest expectation.
  task automatic report(string name, longint exp_v, longint act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    failures++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, actual %p", $time, out_item);
        failures++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (e.bin_index != out_item.bin_index)
          report("bin_index", e.bin_index, out_item.bin_index);
        if (e.discarded != out_item.discarded)
          report("discarded", e.discarded, out_item.discarded);
        if (e.sum_0 != out_item.sum_0) report("sum_0", e.sum_0, out_item.sum_0);
        if (e.sum_1 != out_item.sum_1) report("sum_1", e.sum_1, out_item.sum_1);
        if (e.sum_2 != out_item.sum_2) report("sum_2", e.sum_2, out_item.sum_2);
        if (e.sum_3 != out_item.sum_3) report("sum_3", e.sum_3, out_item.sum_3);
        if (e.hit_count != out_item.hit_count)
          report("hit_count", e.hit_count, out_item.hit_count);
      end
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog. The limit is many times the slowest correct run with its stalls
  // and the reset sweep.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drives one request and waits for its acceptance. The expectation is
  // queued at the edge of acceptance, before the result can appear. Valid
  // stays up after acceptance; the next send or drain decides what follows.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(fold_predict(it));
  endtask

  // Same as send, with the result typed in by hand and checked against
  // the predictor as well, so the directed rows stay honest.
  task automatic send_known(in_item_t it, out_item_t known);
    out_item_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    p = fold_predict(it);
    if (p != known) begin
      $display("%0t: directed row mismatch, expected %p, actual %p", $time, known, p);
      failures++;
    end
    expected_results.push_back(p);
  endtask

  // Stops sending and waits until every result is back, then a few cycles
  // more so that the pipeline is surely empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Registers change only while nothing is in flight.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PHASE_STEP:    step_reg = val;
      CFG_INITIAL_PHASE: start_phase_reg = val;
      CFG_BIN_COUNT:     bins_reg = val[10:0];
      default:           zeroed_reg = val[0];
    endcase
  endtask

  function automatic in_item_t make_req(logic [1:0] kind, logic [9:0] sel,
                                        logic [15:0] s0, logic [15:0] s1,
                                        logic [15:0] s2, logic [15:0] s3,
                                        logic wz);
    in_item_t it;
    it.req_type = kind; it.bin_select = sel;
    it.sample_0 = s0; it.sample_1 = s1; it.sample_2 = s2; it.sample_3 = s3;
    it.weight_zero = wz;
    return it;
  endfunction

  // Random request: mostly folds, with reads near the live bins.
  function automatic in_item_t random_req();
    in_item_t it;
    int pick;
    it = $bits(in_item_t)'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 70) it.req_type = REQ_FOLD;
    else if (pick < 83) it.req_type = REQ_READ;
    else if (pick < 95) it.req_type = REQ_CLEAR;
    else it.req_type = REQ_RESTART;
    if ($urandom_range(3) != 0 && bins_reg != 0)
      it.bin_select = $urandom_range((bins_reg > MaxBins ? MaxBins : bins_reg) - 1);
    if ($urandom_range(5) == 0) it.sample_0 = 0;
    if ($urandom_range(7) == 0) begin
      it.sample_0 = 16'h7fff; it.sample_1 = 16'h8000;
    end
    return it;
  endfunction

  // One directed row: the request and, where it is obvious, its result.
  typedef struct {
    in_item_t  req;
    logic      known;
    out_item_t result;
  } directed_row_t;

  directed_row_t directed_rows [$];

  function automatic out_item_t res(logic [9:0] bin, logic disc, logic [31:0] s0,
                                    logic [31:0] s1, logic [31:0] s2,
                                    logic [31:0] s3, logic [31:0] hc);
    out_item_t r;
    r.bin_index = bin; r.discarded = disc;
    r.sum_0 = s0; r.sum_1 = s1; r.sum_2 = s2; r.sum_3 = s3; r.hit_count = hc;
    return r;
  endfunction

  task automatic add_row(in_item_t it, logic known, out_item_t r);
    directed_row_t row;
    row.req = it; row.known = known; row.result = r;
    directed_rows.push_back(row);
  endtask

  // A burst of the largest samples of both signs into one bin.
  task automatic saturate_bin();
    in_item_t it;
    it = make_req(REQ_FOLD, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
    for (int n = 0; n < 40; n++) send(it);
    send(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    failures = 0;
    send_idle_pct = 9;
    recv_idle_pct = 53;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PHASE_STEP;
    cfg_data = '0;
    step_reg = 0;
    start_phase_reg = 0;
    bins_reg = MaxBins;
    zeroed_reg = 0;
    phase = 0;
    for (int b = 0; b < MaxBins; b++) begin
      hits[b] = 0;
      for (int l = 0; l < Lanes; l++) lane_sums[b][l] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with phase step zero and all bins: every fold lands
    // in bin 0. Reads after reset show cleared stores.
    add_row(make_req(REQ_READ, 10'd1023, 0, 0, 0, 0, 0), 1, res(1023, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_READ, 10'd0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_FOLD, 10'd0, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 0),
            1, res(0, 0, 0, 0, 0, 0, 0));
    // A zero weight drops the sample but reports the bin.
    add_row(make_req(REQ_FOLD, 10'd5, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 1),
            1, res(0, 1, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_READ, 10'd0, 0, 0, 0, 0, 0),
            1, res(0, 0, 32'd32767, -32'sd32768, -32'sd1, 32'd1, 32'd1));
    add_row(make_req(REQ_CLEAR, 10'd0, 0, 0, 0, 0, 0),
            1, res(0, 0, 32'd32767, -32'sd32768, -32'sd1, 32'd1, 32'd1));
    add_row(make_req(REQ_READ, 10'd0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_RESTART, 10'd777, 16'h5555, 0, 0, 0, 1),
            1, res(0, 0, 0, 0, 0, 0, 0));
    foreach (directed_rows[i]) begin
      if (directed_rows[i].known) send_known(directed_rows[i].req, directed_rows[i].result);
      else send(directed_rows[i].req);
    end
    drain();

    // Step of half a turn over three bins: alternates bins 2 and 1,
    // starting from a phase near the top of the turn.
    write_reg(CFG_PHASE_STEP, 32'h8000_0000);
    write_reg(CFG_INITIAL_PHASE, 32'hffff_ffff);
    write_reg(CFG_BIN_COUNT, 32'd3);
    send(make_req(REQ_RESTART, 0, 0, 0, 0, 0, 0));
    for (int n = 0; n < 6; n++)
      send(make_req(REQ_FOLD, 0, 16'(n), 16'hffff, 0, 16'h8000, 1'(n == 3)));
    // Zeroed mode: weights ignored, hits only for nonzero lane 0.
    write_reg(CFG_ZEROED_MODE, 32'd1);
    send(make_req(REQ_FOLD, 0, 16'h0000, 16'h0007, 0, 0, 1));
    send(make_req(REQ_FOLD, 0, 16'h0003, 16'h0007, 0, 0, 1));
    for (int b = 0; b < 3; b++) send(make_req(REQ_CLEAR, 10'(b), 0, 0, 0, 0, 0));
    drain();
    // Bin count of zero acts as one, and above the maximum acts as the maximum.
    write_reg(CFG_BIN_COUNT, 32'd0);
    send(make_req(REQ_FOLD, 0, 16'h0001, 0, 0, 0, 0));
    drain();
    write_reg(CFG_BIN_COUNT, 32'h7ff);
    send(make_req(REQ_FOLD, 0, 16'h0001, 0, 0, 0, 0));
    // Read of the top bin, 1023, returns its stored contents.
    send(make_req(REQ_READ, 10'd1023, 0, 0, 0, 0, 0));
    drain();

    // Extreme samples of both signs, back to back, into bin 0.
    write_reg(CFG_ZEROED_MODE, 32'd0);
    write_reg(CFG_BIN_COUNT, 32'd1);
    write_reg(CFG_PHASE_STEP, 32'h0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    saturate_bin();
    send(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    drain();

    // Random part in six phases over three idling profiles, each phase with fresh settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 9;  recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(CFG_PHASE_STEP, (ph == 5) ? 32'hffff_ffff : $urandom);
      write_reg(CFG_INITIAL_PHASE, (ph == 4) ? 32'h0 : $urandom);
      case (ph)
        0: write_reg(CFG_BIN_COUNT, 32'd1024);
        1: write_reg(CFG_BIN_COUNT, 32'd1);
        2: write_reg(CFG_BIN_COUNT, 32'd2);
        default: write_reg(CFG_BIN_COUNT, $urandom_range(1024, 1));
      endcase
      write_reg(CFG_ZEROED_MODE, ph % 2);
      for (int n = 0; n < 300; n++) begin
        send(random_req());
        // Once in the run, the sender holds off until all results are back.
        if (ph == 1 && n == 150) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ppf_pkg.sv
hw/rtl/ppf_lane.sv
hw/rtl/ppf_hits.sv
hw/rtl/pulse_phase_folder_top.sv
verif/testbench.sv
